// ===== design/lsbp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbp_pkg: shared definitions for the lsb-first bit packer
// request and status codes, field widths and controller/datapath handshake
// ----------------------------------------------------------------------------
package lsbp_pkg;

    localparam int DEF_BUF_BYTES = 4096;

    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 64;
    localparam int COUNT_W  = 7;
    localparam int SEEK_W   = 16;
    localparam int RIDX_W   = 12;
    localparam int STATUS_W = 2;
    localparam int RDATA_W  = 8;
    localparam int BITPOS_W = 16;
    localparam int BLEN_W   = 13;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 40;

    localparam logic [COUNT_W-1:0] MAX_COUNT = 7'd64;

    localparam logic [REQ_W-1:0] REQ_WRITE   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REALIGN = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SEEK    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TAKE    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SEEK_PAST = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic load;
        logic decode;
        logic step;
        logic finish;
    } lsbp_cmd_t;

    typedef struct packed {
        logic need_loop;
        logic last_step;
    } lsbp_sts_t;

endpackage

// ===== design/lsbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsbp_ctrl: request sequencer
// steps each item through decode, the byte loop of a write and the result
// ----------------------------------------------------------------------------
module lsbp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  lsbp_pkg::lsbp_sts_t sts,
    output lsbp_pkg::lsbp_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WRITE,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd.load   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.decode = (state_reg == ST_DECODE);
        cmd.step   = (state_reg == ST_WRITE);
        cmd.finish = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    end

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = sts.need_loop ? ST_WRITE : ST_FINISH;
            end
            ST_WRITE:
            begin
                if (sts.last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (cmd.finish)
                begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== design/lsbp_datapath.sv =====
// ----------------------------------------------------------------------------
// lsbp_datapath: position registers, byte store and byte merge
// one byte read-modify-write per loop step, next byte read ahead
// ----------------------------------------------------------------------------
module lsbp_datapath #(
    parameter int BUF_BYTES = lsbp_pkg::DEF_BUF_BYTES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lsbp_pkg::lsbp_cmd_t               cmd,
    output lsbp_pkg::lsbp_sts_t               sts,
    input  logic [lsbp_pkg::REQ_W-1:0]        req_type,
    input  logic [lsbp_pkg::VALUE_W-1:0]      value,
    input  logic [lsbp_pkg::COUNT_W-1:0]      count,
    input  logic [lsbp_pkg::SEEK_W-1:0]       seek_position,
    input  logic [lsbp_pkg::RIDX_W-1:0]       read_index,
    output logic [lsbp_pkg::STATUS_W-1:0]     status,
    output logic [lsbp_pkg::RDATA_W-1:0]      read_data,
    output logic [lsbp_pkg::BITPOS_W-1:0]     bit_position,
    output logic [lsbp_pkg::BLEN_W-1:0]       byte_length
);

    localparam int ADDR_W = $clog2(BUF_BYTES);
    localparam int LEN_W  = $clog2(BUF_BYTES + 1);
    localparam int POS_W  = LEN_W + 3;
    localparam int SK_W   = (POS_W > lsbp_pkg::SEEK_W) ? POS_W : lsbp_pkg::SEEK_W;
    localparam int RI_W   = (LEN_W > lsbp_pkg::RIDX_W) ? LEN_W : lsbp_pkg::RIDX_W;
    localparam int BP_W   = (POS_W > lsbp_pkg::BITPOS_W) ? POS_W : lsbp_pkg::BITPOS_W;
    localparam int BL_W   = (LEN_W > lsbp_pkg::BLEN_W) ? LEN_W : lsbp_pkg::BLEN_W;
    localparam logic [POS_W:0] POS_LIMIT = (POS_W + 1)'(BUF_BYTES * 8);

    logic [7:0] mem [BUF_BYTES];
    logic [7:0] rd_q_reg;

    logic [lsbp_pkg::REQ_W-1:0]    req_reg;
    logic [lsbp_pkg::VALUE_W-1:0]  val_reg;
    logic [lsbp_pkg::COUNT_W-1:0]  cnt_reg;
    logic [lsbp_pkg::SEEK_W-1:0]   seek_reg;
    logic [lsbp_pkg::RIDX_W-1:0]   ridx_reg;
    logic [lsbp_pkg::COUNT_W-1:0]  rem_reg;
    logic [ADDR_W-1:0]             addr_reg;
    logic [2:0]                    off_reg;
    logic [lsbp_pkg::STATUS_W-1:0] res_status_reg;
    logic                          rd_ok_reg;
    logic [LEN_W-1:0]              take_len_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] far_reg, far_next;
    logic [LEN_W-1:0] used_reg, used_next;

    logic [lsbp_pkg::STATUS_W-1:0] status_reg;
    logic [lsbp_pkg::RDATA_W-1:0]  read_data_reg;
    logic [lsbp_pkg::BITPOS_W-1:0] bit_position_reg;
    logic [lsbp_pkg::BLEN_W-1:0]   byte_length_reg;

    logic [POS_W:0]   pos_sum;
    logic             overflow;
    logic [LEN_W-1:0] pos_ceil;
    logic [POS_W-1:0] pos_round;
    logic [SK_W-1:0]  seek_ext;
    logic [SK_W-1:0]  far_ext;
    logic             seek_bad;
    logic [RI_W-1:0]  ridx_ext;
    logic [RI_W-1:0]  used_ext;
    logic             rd_ok;
    logic [3:0]       room;
    logic [3:0]       take;
    logic [7:0]       low_mask;
    logic [7:0]       byte_mask;
    logic [7:0]       byte_bits;
    logic [7:0]       old_byte;
    logic [7:0]       new_byte;
    logic [POS_W-1:0] pos_step;
    logic [LEN_W-1:0] step_ceil;
    logic             last_step;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BP_W-1:0]  bp_wide;
    logic [BL_W-1:0]  len_wide;
    logic [LEN_W-1:0] len_sel;

    always_comb
    begin
        pos_sum   = {1'b0, pos_reg} + (POS_W + 1)'(cnt_reg);
        overflow  = pos_sum > POS_LIMIT;
        pos_ceil  = LEN_W'(({1'b0, pos_reg} + (POS_W + 1)'(7)) >> 3);
        pos_round = {pos_ceil, 3'b000};
        seek_ext  = SK_W'(seek_reg);
        far_ext   = SK_W'(far_reg);
        seek_bad  = seek_ext > far_ext;
        ridx_ext  = RI_W'(ridx_reg);
        used_ext  = RI_W'(used_reg);
        rd_ok     = ridx_ext < used_ext;
    end

    // byte merge for one loop step
    always_comb
    begin
        room      = 4'd8 - {1'b0, off_reg};
        take      = (lsbp_pkg::COUNT_W'(room) > rem_reg) ? rem_reg[3:0] : room;
        low_mask  = 8'((9'd1 << take) - 9'd1);
        byte_mask = low_mask << off_reg;
        byte_bits = (val_reg[7:0] & low_mask) << off_reg;
        old_byte  = (LEN_W'(addr_reg) >= used_reg) ? 8'd0 : rd_q_reg;
        new_byte  = (old_byte & ~byte_mask) | byte_bits;
        pos_step  = pos_reg + POS_W'(take);
        step_ceil = LEN_W'(({1'b0, pos_step} + (POS_W + 1)'(7)) >> 3);
        last_step = (lsbp_pkg::COUNT_W'(take) == rem_reg);
    end

    always_comb
    begin
        sts.need_loop = (req_reg == lsbp_pkg::REQ_WRITE) && (cnt_reg != '0) && !overflow;
        sts.last_step = last_step;
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = addr_reg + ADDR_W'(1);
        if (cmd.decode)
        begin
            rd_en   = 1'b1;
            rd_addr = (req_reg == lsbp_pkg::REQ_READ) ? ridx_ext[ADDR_W-1:0]
                                                      : pos_reg[ADDR_W+2:3];
        end
        else if (cmd.step)
        begin
            rd_en = 1'b1;
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        far_next  = far_reg;
        used_next = used_reg;
        if (cmd.decode)
        begin
            unique case (req_reg)
                lsbp_pkg::REQ_WRITE:
                begin
                    if (!overflow && cnt_reg == '0 && used_reg < pos_ceil)
                    begin
                        used_next = pos_ceil;
                    end
                end
                lsbp_pkg::REQ_REALIGN:
                begin
                    pos_next = pos_round;
                    if (used_reg < pos_ceil)
                    begin
                        used_next = pos_ceil;
                    end
                    if (far_reg < pos_round)
                    begin
                        far_next = pos_round;
                    end
                end
                lsbp_pkg::REQ_SEEK:
                begin
                    if (!seek_bad)
                    begin
                        pos_next = POS_W'(seek_ext);
                    end
                end
                lsbp_pkg::REQ_TAKE:
                begin
                    pos_next  = '0;
                    far_next  = '0;
                    used_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.step)
        begin
            pos_next = pos_step;
            if (last_step)
            begin
                if (far_reg < pos_step)
                begin
                    far_next = pos_step;
                end
                if (used_reg < step_ceil)
                begin
                    used_next = step_ceil;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            far_reg  <= '0;
            used_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            far_reg  <= far_next;
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            mem[addr_reg] <= new_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        len_sel  = (req_reg == lsbp_pkg::REQ_TAKE) ? take_len_reg : used_reg;
        bp_wide  = BP_W'(pos_reg);
        len_wide = BL_W'(len_sel);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req_type;
            val_reg  <= value;
            cnt_reg  <= (count > lsbp_pkg::MAX_COUNT) ? lsbp_pkg::MAX_COUNT : count;
            seek_reg <= seek_position;
            ridx_reg <= read_index;
        end
        if (cmd.decode)
        begin
            addr_reg     <= pos_reg[ADDR_W+2:3];
            off_reg      <= pos_reg[2:0];
            rem_reg      <= cnt_reg;
            rd_ok_reg    <= (req_reg == lsbp_pkg::REQ_READ) && rd_ok;
            take_len_reg <= (used_reg < pos_ceil) ? pos_ceil : used_reg;
            if (req_reg == lsbp_pkg::REQ_WRITE && overflow)
            begin
                res_status_reg <= lsbp_pkg::ST_OVERFLOW;
            end
            else if (req_reg == lsbp_pkg::REQ_SEEK && seek_bad)
            begin
                res_status_reg <= lsbp_pkg::ST_SEEK_PAST;
            end
            else
            begin
                res_status_reg <= lsbp_pkg::ST_OK;
            end
        end
        if (cmd.step)
        begin
            val_reg  <= val_reg >> take;
            rem_reg  <= rem_reg - lsbp_pkg::COUNT_W'(take);
            off_reg  <= 3'd0;
            addr_reg <= addr_reg + ADDR_W'(1);
        end
        if (cmd.finish)
        begin
            status_reg       <= res_status_reg;
            read_data_reg    <= rd_ok_reg ? rd_q_reg : 8'd0;
            bit_position_reg <= bp_wide[lsbp_pkg::BITPOS_W-1:0];
            byte_length_reg  <= len_wide[lsbp_pkg::BLEN_W-1:0];
        end
    end

    assign status       = status_reg;
    assign read_data    = read_data_reg;
    assign bit_position = bit_position_reg;
    assign byte_length  = byte_length_reg;

endmodule

// ===== design/lsb_first_bit_packer_core.sv =====
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_core: lsb-first bit packer with byte store
// packs fields into a byte store, supports realign, seek, read and take
// ----------------------------------------------------------------------------
// One request in, one result out. A write whose field touches k bytes passes
// through accept, decode, one loop step per byte and result; other requests,
// and writes of zero bits or writes that overflow, skip the byte loop. The per-byte
// loop is set by the byte store's single write port, with the next byte read
// ahead on the read port. A new request is taken while the last result still
// waits in the output register. Bytes past the fill count read as zero, so no
// clearing pass is needed after reset or take.
module lsb_first_bit_packer_core #(
    parameter int BUF_BYTES = lsbp_pkg::DEF_BUF_BYTES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // value, count, seek_position, read_index
    input  logic [lsbp_pkg::S_TDATA_W-1:0]    s_tdata,
    // req_type
    input  logic [lsbp_pkg::REQ_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // read_data, bit_position, byte_length
    output logic [lsbp_pkg::M_TDATA_W-1:0]    m_tdata,
    // status
    output logic [lsbp_pkg::STATUS_W-1:0]     m_tuser
);

    lsbp_pkg::lsbp_cmd_t cmd;
    lsbp_pkg::lsbp_sts_t sts;

    logic [lsbp_pkg::RDATA_W-1:0]  read_data;
    logic [lsbp_pkg::BITPOS_W-1:0] bit_position;
    logic [lsbp_pkg::BLEN_W-1:0]   byte_length;

    lsbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lsbp_datapath #(
        .BUF_BYTES (BUF_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_type      (s_tuser),
        .value         (s_tdata[63:0]),
        .count         (s_tdata[70:64]),
        .seek_position (s_tdata[86:71]),
        .read_index    (s_tdata[98:87]),
        .status        (m_tuser),
        .read_data     (read_data),
        .bit_position  (bit_position),
        .byte_length   (byte_length)
    );

    assign m_tdata = {3'b000, byte_length, bit_position, read_data};

endmodule

// ===== tb/lsb_first_bit_packer_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_core_test: self-checking bench for the bit packer
// drives write, realign, seek, read, take and unknown requests on the input stream,
// predicts each result from a local copy of the byte store and compares it
// field by field with what comes out, under random gaps and output stalls
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_core_test;
    import lsbp_pkg::*;

    localparam int          STORE_BYTES = DEF_BUF_BYTES;
    localparam int          STORE_BITS  = STORE_BYTES * 8;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_WAIT  = 40;
    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RDATA_W-1:0]  read_data;
        logic [BITPOS_W-1:0] bit_position;
        logic [BLEN_W-1:0]   byte_length;
    } packer_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [REQ_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // packer state as the block should hold it
    logic [7:0]            store_copy [0:STORE_BYTES-1];
    int unsigned           write_bit;
    int unsigned           highest_bit;
    int unsigned           bytes_used;

    packer_result_t        pending_results [$];
    int                    mismatch_count;
    int unsigned           cycle_count;
    bit                    idle_en;
    int                    hold_req;
    int                    hold_ack;
    int                    hold_left;

    lsb_first_bit_packer_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic void grow_store(int unsigned bytes);
        int unsigned limit;
        limit = (bytes > STORE_BYTES) ? STORE_BYTES : bytes;
        while (bytes_used < limit)
        begin
            store_copy[bytes_used] = 8'h00;
            bytes_used++;
        end
    endfunction

    function automatic void round_up_position();
        write_bit = (write_bit + 7) / 8 * 8;
        grow_store(write_bit / 8);
        if (highest_bit < write_bit)
            highest_bit = write_bit;
    endfunction

    function automatic packer_result_t predict_packer(logic [REQ_W-1:0] req,
            logic [VALUE_W-1:0] value, logic [COUNT_W-1:0] count,
            logic [SEEK_W-1:0] seek_pos, logic [RIDX_W-1:0] read_idx);
        packer_result_t res;
        int unsigned    nbits;
        int unsigned    idx;
        int unsigned    off;
        int unsigned    chunk;
        int unsigned    mask;
        int unsigned    bits;
        int unsigned    len;
        logic [63:0]    rest;
        res = '0;
        case (req)
            REQ_WRITE:
            begin
                nbits = (count > MAX_COUNT) ? 64 : count;
                if (write_bit + nbits > STORE_BITS)
                    res.status = ST_OVERFLOW;
                else
                begin
                    grow_store((write_bit + nbits + 7) / 8);
                    rest = value;
                    while (nbits > 0)
                    begin
                        idx   = write_bit / 8;
                        off   = write_bit % 8;
                        chunk = 8 - off;
                        if (chunk > nbits)
                            chunk = nbits;
                        mask = (((32'd1 << chunk) - 1) << off) & 32'hFF;
                        bits = ((32'(rest[7:0]) & ((32'd1 << chunk) - 1)) << off) & 32'hFF;
                        store_copy[idx] = (store_copy[idx] & ~mask[7:0]) | bits[7:0];
                        rest      = rest >> chunk;
                        nbits     = nbits - chunk;
                        write_bit = write_bit + chunk;
                    end
                    if (highest_bit < write_bit)
                        highest_bit = write_bit;
                end
            end
            REQ_REALIGN:
                round_up_position();
            REQ_SEEK:
            begin
                if (seek_pos > highest_bit)
                    res.status = ST_SEEK_PAST;
                else
                    write_bit = seek_pos;
            end
            REQ_READ:
            begin
                if (read_idx < bytes_used)
                    res.read_data = store_copy[read_idx];
            end
            default:
            begin
            end
        endcase
        len = bytes_used;
        if (req == REQ_TAKE)
        begin
            round_up_position();
            len         = bytes_used;
            write_bit   = 0;
            highest_bit = 0;
            bytes_used  = 0;
        end
        res.bit_position = write_bit[BITPOS_W-1:0];
        res.byte_length  = len[BLEN_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
        mismatch_count++;
    endtask

    // entered and left at a falling edge
    task automatic send_request(logic [REQ_W-1:0] req, logic [VALUE_W-1:0] value,
            logic [COUNT_W-1:0] count, logic [SEEK_W-1:0] seek_pos,
            logic [RIDX_W-1:0] read_idx);
        if (idle_en && $urandom_range(99) < 13)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < 13)
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {5'b0, read_idx, seek_pos, count, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(predict_packer(req, value, count, seek_pos, read_idx));
        @(negedge clk);
    endtask

    task automatic send_write(logic [COUNT_W-1:0] count, logic [VALUE_W-1:0] value);
        send_request(REQ_WRITE, value, count, 16'($urandom), 12'($urandom));
    endtask

    task automatic send_simple(logic [REQ_W-1:0] req, logic [SEEK_W-1:0] seek_pos,
            logic [RIDX_W-1:0] read_idx);
        send_request(req, {$urandom, $urandom}, 7'($urandom), seek_pos, read_idx);
    endtask

    always @(posedge clk)
    begin
        packer_result_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected item", 1, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", m_tuser, want.status);
                if (m_tdata[7:0] !== want.read_data)
                    report_mismatch("read_data", m_tdata[7:0], want.read_data);
                if (m_tdata[23:8] !== want.bit_position)
                    report_mismatch("bit_position", m_tdata[23:8], want.bit_position);
                if (m_tdata[36:24] !== want.byte_length)
                    report_mismatch("byte_length", m_tdata[36:24], want.byte_length);
                if (m_tdata[39:37] !== 3'b0)
                    report_mismatch("tdata pad", m_tdata[39:37], 0);
            end
        end
    end

    // output side: random stalls plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(idle_en && $urandom_range(99) < 13);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_directed_requests();
        send_write(7'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_write(7'd1, 64'h1);
        send_write(7'd64, 64'hFFFF_FFFF_FFFF_FFFF);
        send_write(7'd100, 64'hA5A5_5A5A_0F0F_F0F0);
        send_write(7'd127, 64'h0123_4567_89AB_CDEF);
        send_write(7'd3, 64'hFFFF_FFFF_FFFF_FFFA);
        send_simple(REQ_REALIGN, 16'd0, 12'd0);
        send_simple(REQ_READ, 16'd0, 12'd0);
        send_simple(REQ_READ, 16'd0, 12'd8);
        send_simple(REQ_READ, 16'd0, 12'd30);
        send_simple(REQ_READ, 16'd0, 12'd4095);
        // back-patch inside an already written byte
        send_simple(REQ_SEEK, 16'd3, 12'd0);
        send_write(7'd5, 64'h0);
        send_simple(REQ_READ, 16'd0, 12'd0);
        send_simple(REQ_SEEK, 16'hFFFF, 12'd0);
        send_simple(REQ_SEEK, 16'(highest_bit), 12'd0);
        send_simple(REQ_SEEK, 16'(highest_bit + 1), 12'd0);
        send_simple(3'd5, 16'd0, 12'd0);
        send_simple(3'd6, 16'd0, 12'd0);
        send_simple(3'd7, 16'd0, 12'd0);
        send_simple(REQ_TAKE, 16'd0, 12'd0);
        send_simple(REQ_TAKE, 16'd0, 12'd0);
        send_simple(REQ_READ, 16'd0, 12'd0);
        send_simple(REQ_REALIGN, 16'd0, 12'd0);
    endtask

    task automatic test_store_full();
        send_simple(REQ_TAKE, 16'd0, 12'd0);
        for (int i = 0; i < STORE_BYTES / 8; i++)
            send_write(7'd64, {$urandom, $urandom});
        send_write(7'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_write(7'd1, 64'h1);
        send_simple(REQ_READ, 16'd0, 12'd4095);
        send_simple(REQ_SEEK, 16'(STORE_BITS - 5), 12'd0);
        send_write(7'd8, 64'hFF);
        send_write(7'd5, 64'h15);
        send_simple(REQ_READ, 16'd0, 12'd4095);
        send_simple(REQ_SEEK, 16'(STORE_BITS), 12'd0);
        send_simple(REQ_REALIGN, 16'd0, 12'd0);
        send_simple(REQ_TAKE, 16'd0, 12'd0);
    endtask

    task automatic test_output_backpressure();
        idle_en  = 1'b0;
        hold_req = hold_req + 1;
        for (int i = 0; i < 30; i++)
            send_write(7'($urandom_range(64)), {$urandom, $urandom});
        send_simple(REQ_TAKE, 16'd0, 12'd0);
        idle_en = 1'b1;
    endtask

    task automatic test_random_traffic(int num_items);
        int unsigned      pick;
        logic [COUNT_W-1:0] count;
        logic [SEEK_W-1:0]  seek_pos;
        logic [RIDX_W-1:0]  read_idx;
        for (int i = 0; i < num_items; i++)
        begin
            idle_en = !(i >= 500 && i < 700);
            pick    = $urandom_range(99);
            if (pick < 55)
            begin
                if ($urandom_range(9) < 7)
                    count = 7'($urandom_range(16));
                else if ($urandom_range(2) < 2)
                    count = 7'($urandom_range(64, 17));
                else
                    count = 7'($urandom);
                send_write(count, {$urandom, $urandom});
            end
            else if (pick < 63)
                send_simple(REQ_REALIGN, 16'($urandom), 12'($urandom));
            else if (pick < 75)
            begin
                if ($urandom_range(9) < 8)
                    seek_pos = 16'($urandom_range(highest_bit));
                else
                    seek_pos = 16'($urandom);
                send_simple(REQ_SEEK, seek_pos, 12'($urandom));
            end
            else if (pick < 90)
            begin
                if ($urandom_range(9) < 8)
                    read_idx = 12'($urandom_range((bytes_used > 4095) ? 4095 : bytes_used));
                else
                    read_idx = 12'($urandom);
                send_simple(REQ_READ, 16'($urandom), read_idx);
            end
            else if (pick < 97)
                send_simple(REQ_TAKE, 16'($urandom), 12'($urandom));
            else
                send_simple(3'($urandom_range(7, 5)), 16'($urandom), 12'($urandom));
        end
        idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        idle_en        = 1'b1;
        hold_req       = 0;
        hold_ack       = 0;
        hold_left      = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        write_bit      = 0;
        highest_bit    = 0;
        bytes_used     = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_requests();
        test_store_full();
        test_output_backpressure();
        test_random_traffic(770);

        s_tvalid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
